FILE: src/assert_macros.svh
// Assertion macros shared by the ray/box intersect RTL.
// Depends on nothing; the including module supplies clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous active-low reset disable.
`define RBSI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ray box intersect check failed");

// Implication form, a shorthand for antecedent |-> consequent.
`define RBSI_IMPLY(lbl, ante, cons) \
  `RBSI_ASSERT(lbl, (ante) |-> (cons))

`endif

FILE: src/rbsi_pkg.sv
// Package for the ray/box slab intersect block: widths, constants and
// the record that travels along the divider cell chain. No dependencies.
`default_nettype none

package rbsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int NUM_W     = DATA_W + FRAC_BITS;
  localparam int T_W       = NUM_W + 1;
  localparam int AXES      = 3;
  localparam int LANES     = 2 * AXES;

  // Sentinels lie outside every real quotient, whose magnitude stays below 2^NUM_W - 1.
  localparam logic signed [T_W-1:0] T_POS    = {1'b0, {NUM_W{1'b1}}};
  localparam logic signed [T_W-1:0] T_NEG    = -T_POS;
  localparam logic signed [T_W-1:0] DIST_SAT = {{(T_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};

  typedef struct packed {
    logic [LANES-1:0][NUM_W-1:0]  num;
    logic [LANES-1:0][DATA_W-1:0] rem;
    logic [LANES-1:0][NUM_W-1:0]  quo;
    logic [LANES-1:0][DATA_W-1:0] dvs;
    logic [LANES-1:0]             qneg;
    logic [AXES-1:0]              dzero;
    logic [AXES-1:0]              dneg;
    logic                         zmiss;
  } div_t;

endpackage

`default_nettype wire

FILE: src/rbsi_if.sv
// Valid/ready channel interfaces for rays in and results out.
// Depends on nothing.
`default_nettype none

interface rbsi_ray_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  logic signed [31:0] min_x;
  logic signed [31:0] min_y;
  logic signed [31:0] min_z;
  logic signed [31:0] max_x;
  logic signed [31:0] max_y;
  logic signed [31:0] max_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  min_x, min_y, min_z, max_x, max_y, max_z, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface rbsi_res_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] distance;

  modport source (output valid, hit, distance, input ready);
  modport sink (input valid, hit, distance, output ready);
endinterface

`default_nettype wire

FILE: src/ray_box_slab_intersect_core.sv
// Top level of the ray versus axis-aligned box slab test.
// Depends on rbsi_pkg, rbsi_if, rbsi_div_cell, rbsi_resolve, assert_macros.svh.
//
// Usage: each item on ray_i carries a ray origin and direction and the box
// min and max corners, all signed Q16.16. Each item yields exactly one item
// on res_o: hit, and the saturated non-negative hit distance (0 on a miss).
// The path runs through one input stage forming plane minus origin, one cell
// per quotient bit in the divider chain (six restoring divisions run side by
// side), then three stages that order, reduce and saturate. Every stage is
// fully pipelined, so one item is taken every cycle while the receiver does
// not stall.
// When the receiver stalls with a result pending, the whole pipeline holds
// and ray_i.ready drops in the same cycle; it rises again once the result
// register is taken. ray_i.ready is high whenever the result register is
// empty or being taken, even with items still in flight.
// Reset clears all valid flags; data registers are not reset.
`default_nettype none

module ray_box_slab_intersect_core (
  input wire logic clk_i,
  input wire logic rst_ni,
  rbsi_ray_if.sink   ray_i,
  rbsi_res_if.source res_o
);
  import rbsi_pkg::*;

  // Global advance: the pipeline moves whenever the output register can
  // accept a new value.
  logic en;
  assign en          = !res_o.valid || res_o.ready;
  assign ray_i.ready = en;

  logic signed [DATA_W-1:0] org [AXES];
  logic signed [DATA_W-1:0] dir [AXES];
  logic signed [DATA_W-1:0] pln [LANES];

  assign org[0] = ray_i.origin_x;
  assign org[1] = ray_i.origin_y;
  assign org[2] = ray_i.origin_z;
  assign dir[0] = ray_i.dir_x;
  assign dir[1] = ray_i.dir_y;
  assign dir[2] = ray_i.dir_z;
  assign pln[0] = ray_i.min_x;
  assign pln[1] = ray_i.max_x;
  assign pln[2] = ray_i.min_y;
  assign pln[3] = ray_i.max_y;
  assign pln[4] = ray_i.min_z;
  assign pln[5] = ray_i.max_z;

  // Input stage: exact 33-bit plane minus origin, split into magnitude and
  // sign so the chain divides unsigned values. A zero direction component
  // is resolved here against its slab and never reaches a quotient.
  div_t                 prep_d;
  div_t                 prep_q;
  logic                 prep_valid_q;
  logic signed [DATA_W:0] diff;
  logic [DATA_W:0]      mag;
  logic [DATA_W-1:0]    dmag;

  always_comb begin
    prep_d = '0;
    diff   = '0;
    mag    = '0;
    dmag   = '0;
    for (int a = 0; a < AXES; a++) begin
      dmag = dir[a][DATA_W-1] ? -dir[a] : dir[a];
      prep_d.dzero[a] = (dir[a] == '0);
      prep_d.dneg[a]  = dir[a][DATA_W-1];
      if ((dir[a] == '0) && ((org[a] < pln[2*a]) || (org[a] > pln[2*a+1]))) begin
        prep_d.zmiss = 1'b1;
      end
      for (int k = 0; k < 2; k++) begin
        diff = {pln[2*a+k][DATA_W-1], pln[2*a+k]} - {org[a][DATA_W-1], org[a]};
        mag  = diff[DATA_W] ? -diff : diff;
        prep_d.num[2*a+k]  = {mag[DATA_W-1:0], {FRAC_BITS{1'b0}}};
        prep_d.dvs[2*a+k]  = dmag;
        prep_d.qneg[2*a+k] = diff[DATA_W] ^ dir[a][DATA_W-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
    end else if (en) begin
      prep_valid_q <= ray_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_q <= prep_d;
    end
  end

  // Divider chain: cell i settles quotient bit NUM_W-1-i of all six lanes.
  logic chain_valid [NUM_W+1];
  div_t chain_data  [NUM_W+1];

  assign chain_valid[0] = prep_valid_q;
  assign chain_data[0]  = prep_q;

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    rbsi_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[i]),
      .data_i  (chain_data[i]),
      .valid_o (chain_valid[i+1]),
      .data_o  (chain_data[i+1])
    );
  end

  // Back end: signing, slab ordering, reduction and the result register.
  rbsi_resolve u_resolve (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (chain_valid[NUM_W]),
    .data_i     (chain_data[NUM_W]),
    .valid_o    (res_o.valid),
    .hit_o      (res_o.hit),
    .distance_o (res_o.distance)
  );

`include "assert_macros.svh"

  `RBSI_IMPLY(a_miss_zero, res_o.valid && !res_o.hit, res_o.distance == '0)
  `RBSI_IMPLY(a_dist_nonneg, res_o.valid, !res_o.distance[31])
  `RBSI_ASSERT(a_ready_rule, ray_i.ready == (!res_o.valid || res_o.ready))
  `RBSI_IMPLY(a_hold_stall, res_o.valid && !res_o.ready && !ray_i.ready, ##1 res_o.valid)

endmodule

`default_nettype wire

FILE: src/rbsi_div_cell.sv
// One cell of the divider chain: resolves one quotient bit for all six
// slab divisions and passes the record on. Depends on rbsi_pkg.
`default_nettype none

module rbsi_div_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire rbsi_pkg::div_t data_i,
  output logic               valid_o,
  output rbsi_pkg::div_t     data_o
);
  import rbsi_pkg::*;

  div_t            data_d;
  div_t            data_q;
  logic            valid_q;
  logic [DATA_W:0] r_sh;
  logic [DATA_W:0] r_dif;
  logic            ge;

  always_comb begin
    data_d = data_i;
    r_sh   = '0;
    r_dif  = '0;
    ge     = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      r_sh  = {data_i.rem[l], data_i.num[l][NUM_W-1]};
      r_dif = r_sh - {1'b0, data_i.dvs[l]};
      ge    = (r_sh >= {1'b0, data_i.dvs[l]});
      data_d.rem[l] = ge ? r_dif[DATA_W-1:0] : r_sh[DATA_W-1:0];
      data_d.num[l] = {data_i.num[l][NUM_W-2:0], 1'b0};
      data_d.quo[l] = {data_i.quo[l][NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

`default_nettype wire

FILE: src/rbsi_resolve.sv
// Back end: signs the quotients, forms entry/exit per axis, reduces them
// and produces the registered hit and distance. Depends on rbsi_pkg.
`default_nettype none

module rbsi_resolve (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire rbsi_pkg::div_t data_i,
  output logic               valid_o,
  output logic               hit_o,
  output logic signed [31:0] distance_o
);
  import rbsi_pkg::*;

  logic signed [T_W-1:0] ent_d [AXES];
  logic signed [T_W-1:0] ext_d [AXES];
  logic signed [T_W-1:0] ent_q [AXES];
  logic signed [T_W-1:0] ext_q [AXES];
  logic                  zmiss_a_q;
  logic                  valid_a_q;
  logic signed [T_W-1:0] q0;
  logic signed [T_W-1:0] q1;

  logic signed [T_W-1:0] entm_d, extm_d, entm_q, extm_q;
  logic                  zmiss_b_q;
  logic                  valid_b_q;

  logic signed [T_W-1:0] dsel;
  logic                  hit_d;
  logic signed [31:0]    dist_d;
  logic                  hit_q;
  logic signed [31:0]    dist_q;
  logic                  valid_c_q;

  // Stage A: signed quotients, swapped for a negative direction; sentinels for a zero direction.
  always_comb begin
    q0 = '0;
    q1 = '0;
    for (int a = 0; a < AXES; a++) begin
      q0 = data_i.qneg[2*a]   ? -$signed({1'b0, data_i.quo[2*a]})
                              :  $signed({1'b0, data_i.quo[2*a]});
      q1 = data_i.qneg[2*a+1] ? -$signed({1'b0, data_i.quo[2*a+1]})
                              :  $signed({1'b0, data_i.quo[2*a+1]});
      if (data_i.dzero[a]) begin
        ent_d[a] = T_NEG;
        ext_d[a] = T_POS;
      end else if (data_i.dneg[a]) begin
        ent_d[a] = q1;
        ext_d[a] = q0;
      end else begin
        ent_d[a] = q0;
        ext_d[a] = q1;
      end
    end
  end

  // Stage B: largest entry, smallest exit.
  always_comb begin
    entm_d = ent_q[0];
    extm_d = ext_q[0];
    for (int a = 1; a < AXES; a++) begin
      if (ent_q[a] > entm_d) entm_d = ent_q[a];
      if (ext_q[a] < extm_d) extm_d = ext_q[a];
    end
  end

  // Stage C: miss test, distance choice and saturation.
  always_comb begin
    dsel   = (entm_q >= 0) ? entm_q : extm_q;
    hit_d  = !zmiss_b_q && !(extm_q < entm_q) && (dsel >= 0);
    dist_d = '0;
    if (hit_d) begin
      dist_d = (dsel > DIST_SAT) ? DIST_SAT[31:0] : dsel[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ent_q     <= ent_d;
      ext_q     <= ext_d;
      zmiss_a_q <= data_i.zmiss;
      entm_q    <= entm_d;
      extm_q    <= extm_d;
      zmiss_b_q <= zmiss_a_q;
      hit_q     <= hit_d;
      dist_q    <= dist_d;
    end
  end

  assign valid_o    = valid_c_q;
  assign hit_o      = hit_q;
  assign distance_o = dist_q;
endmodule

`default_nettype wire
